FILE: rtl/act_pkg.sv
`timescale 1ns / 1ps

package act_pkg;

	// width of the count fields in a result transaction
	localparam int unsigned RSP_COUNT_W = 6;

	// command codes
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_APPEND  = 2'd1;
	localparam logic [1:0] CMD_CONFIRM = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] tag;
		logic [7:0] count;
		logic [7:0] format;
	} act_req_t;

	typedef struct packed {
		logic                   accepted;
		logic                   added;
		logic                   done_res;
		logic                   reset_confirmed;
		logic [RSP_COUNT_W-1:0] confirmed_count;
		logic [RSP_COUNT_W-1:0] reference_count;
	} act_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_PAIR,
		ST_PAIR_END,
		ST_FIN
	} act_state_t;

endpackage

FILE: rtl/act_ram.sv
`timescale 1ns / 1ps

module act_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/association_confirm_tracker_unit.sv
`timescale 1ns / 1ps
// clear, append and unused commands: the transaction goes through FIN into the result register
// confirm: the table scan over all ENTRIES entries and SCAN_END, or also the pairwise walk
//   over n*n pairs and PAIR_END when the confirmed count reaches a nonzero reference count n,
//   each reading one entry of each table memory per cycle, then FIN; a stalled result holds FIN
// one transaction is processed at a time; a new one is taken while a result waits
// reset clears both counts, the control state and the result valid flag; tables are not cleared
module association_confirm_tracker_unit #(
	parameter int unsigned ENTRIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  act_pkg::act_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output act_pkg::act_rsp_t rsp
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned MW = (CW > 8) ? CW : 8;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	act_pkg::act_state_t state_q, state_n;

	// latched transaction
	logic [7:0] tag_q, fmt_q, cnt_q;

	logic [CW-1:0] ref_count_q, conf_count_q;
	logic [AW-1:0] k_q, u_q;

	// memory ports
	logic          ref_we, conf_we;
	logic [AW-1:0] ref_waddr, conf_waddr, ref_raddr, conf_raddr;
	logic [15:0]   ref_wdata, ref_rdata, conf_rdata;

	logic          scan_v_s1, pair_v_s1;
	logic [AW-1:0] idx_s1;

	logic ref_hit_q, conf_hit_q, ref_hit_c, conf_hit_c;
	logic [CW-1:0] hits_q, hits_c;
	logic over_q, over_c;

	logic acc_q, add_q, done_q, rst_q;
	logic acc_c, add_c, go_pair, done_c, rst_c;
	logic [CW-1:0] conf_count_new;

	logic req_accept, scan_issue, pair_issue, rsp_load;
	logic scan_last, pair_last, k_last;
	logic rsp_valid_q;
	act_pkg::act_rsp_t rsp_q;

	assign req_accept = req_valid && !req_stall;

	// table memories, entry is {tag, format}
	act_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_ref_ram (
		.clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
		.raddr(ref_raddr), .rdata(ref_rdata)
	);

	act_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_conf_ram (
		.clk(clk), .we(conf_we), .waddr(conf_waddr), .wdata({tag_q, fmt_q}),
		.raddr(conf_raddr), .rdata(conf_rdata)
	);

	// reference append straight from the incoming transaction
	assign ref_we    = req_accept && req.command == act_pkg::CMD_APPEND
		&& ref_count_q != CW'(ENTRIES);
	assign ref_waddr = AW'(ref_count_q);
	assign ref_wdata = {req.tag, req.format};

	assign ref_raddr  = k_q;
	assign conf_raddr = scan_issue ? k_q : u_q;
	assign conf_waddr = AW'(conf_count_q);
	assign conf_we    = state_q == act_pkg::ST_SCAN_END && add_c;

	// membership flags including the entry arriving this cycle
	always_comb begin
		ref_hit_c  = ref_hit_q;
		conf_hit_c = conf_hit_q;
		if (scan_v_s1) begin
			if (CW'(idx_s1) < ref_count_q && ref_rdata == {tag_q, fmt_q}) begin
				ref_hit_c = 1'b1;
			end
			if (CW'(idx_s1) < conf_count_q && conf_rdata == {tag_q, fmt_q}) begin
				conf_hit_c = 1'b1;
			end
		end
	end

	// pairwise match count, saturating past the reference count
	always_comb begin
		hits_c = hits_q;
		over_c = over_q;
		if (pair_v_s1 && ref_rdata == conf_rdata) begin
			if (hits_q == ref_count_q) begin
				over_c = 1'b1;
			end else begin
				hits_c = CW'(hits_q + 1'b1);
			end
		end
	end

	// decision after the scan and after the pairwise walk
	always_comb begin
		acc_c = MW'(ref_count_q) == MW'(cnt_q) && ref_hit_c;
		add_c = acc_c && !conf_hit_c && conf_count_q != CW'(ENTRIES);
		conf_count_new = add_c ? CW'(conf_count_q + 1'b1) : conf_count_q;
		go_pair = conf_count_new == ref_count_q && ref_count_q != '0;
		if (state_q == act_pkg::ST_PAIR_END) begin
			done_c = !over_c && hits_c == ref_count_q;
			rst_c  = !done_c;
		end else begin
			done_c = ref_count_q == '0;
			rst_c  = !done_c && conf_count_new >= ref_count_q;
		end
	end

	assign scan_last = k_q == LAST;
	assign k_last    = k_q == AW'(ref_count_q - 1'b1);
	assign pair_last = k_last && u_q == AW'(ref_count_q - 1'b1);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			act_pkg::ST_IDLE: begin
				if (req_accept) begin
					state_n = (req.command == act_pkg::CMD_CONFIRM) ?
						act_pkg::ST_SCAN : act_pkg::ST_FIN;
				end
			end
			act_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_n = act_pkg::ST_SCAN_END;
				end
			end
			act_pkg::ST_SCAN_END: begin
				state_n = go_pair ? act_pkg::ST_PAIR : act_pkg::ST_FIN;
			end
			act_pkg::ST_PAIR: begin
				if (pair_last) begin
					state_n = act_pkg::ST_PAIR_END;
				end
			end
			act_pkg::ST_PAIR_END: begin
				state_n = act_pkg::ST_FIN;
			end
			act_pkg::ST_FIN: begin
				if (rsp_load) begin
					state_n = act_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = act_pkg::ST_IDLE;
			end
		endcase
	end

	// state machine outputs
	always_comb begin
		req_stall  = state_q != act_pkg::ST_IDLE;
		scan_issue = state_q == act_pkg::ST_SCAN;
		pair_issue = state_q == act_pkg::ST_PAIR;
		rsp_load   = state_q == act_pkg::ST_FIN && (!rsp_valid_q || !rsp_stall);
	end

	// control and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= act_pkg::ST_IDLE;
			ref_count_q  <= '0;
			conf_count_q <= '0;
			scan_v_s1    <= 1'b0;
			pair_v_s1    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_n;
			scan_v_s1 <= scan_issue;
			pair_v_s1 <= pair_issue;
			if (req_accept && req.command == act_pkg::CMD_CLEAR) begin
				ref_count_q  <= '0;
				conf_count_q <= '0;
			end
			if (ref_we) begin
				ref_count_q <= CW'(ref_count_q + 1'b1);
			end
			if (state_q == act_pkg::ST_SCAN_END) begin
				if (!go_pair && rst_c) begin
					conf_count_q <= '0;
				end else begin
					conf_count_q <= conf_count_new;
				end
			end
			if (state_q == act_pkg::ST_PAIR_END && rst_c) begin
				conf_count_q <= '0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// walk indexes, flags and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= k_q;
		if (req_accept) begin
			tag_q      <= req.tag;
			cnt_q      <= req.count;
			fmt_q      <= req.format;
			k_q        <= '0;
			u_q        <= '0;
			ref_hit_q  <= 1'b0;
			conf_hit_q <= 1'b0;
			acc_q      <= 1'b0;
			add_q      <= ref_we;
			done_q     <= 1'b0;
			rst_q      <= 1'b0;
		end
		if (scan_v_s1) begin
			ref_hit_q  <= ref_hit_c;
			conf_hit_q <= conf_hit_c;
		end
		if (scan_issue) begin
			k_q <= scan_last ? '0 : AW'(k_q + 1'b1);
		end
		if (state_q == act_pkg::ST_SCAN_END) begin
			acc_q  <= acc_c;
			add_q  <= add_c;
			hits_q <= '0;
			over_q <= 1'b0;
			u_q    <= '0;
			if (!go_pair) begin
				done_q <= done_c;
				rst_q  <= rst_c;
			end
		end
		if (pair_issue) begin
			if (k_last) begin
				k_q <= '0;
				u_q <= AW'(u_q + 1'b1);
			end else begin
				k_q <= AW'(k_q + 1'b1);
			end
		end
		if (pair_v_s1) begin
			hits_q <= hits_c;
			over_q <= over_c;
		end
		if (state_q == act_pkg::ST_PAIR_END) begin
			done_q <= done_c;
			rst_q  <= rst_c;
		end
		if (rsp_load) begin
			rsp_q.accepted        <= acc_q;
			rsp_q.added           <= add_q;
			rsp_q.done_res        <= done_q;
			rsp_q.reset_confirmed <= rst_q;
			rsp_q.confirmed_count <= act_pkg::RSP_COUNT_W'(conf_count_q);
			rsp_q.reference_count <= act_pkg::RSP_COUNT_W'(ref_count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_ref_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ref_count_q <= CW'(ENTRIES))
		else $error("reference count beyond table depth");

	a_conf_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		conf_count_q <= CW'(ENTRIES))
		else $error("confirmed count beyond table depth");

	a_pair_equal_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == act_pkg::ST_PAIR |-> ref_count_q == conf_count_q && ref_count_q != '0)
		else $error("pairwise walk with unequal or empty tables");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> state_q != act_pkg::ST_IDLE)
		else $error("transaction accepted without leaving idle");

	a_done_xor_reset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.done_res && rsp_q.reset_confirmed))
		else $error("result both done and reset");

endmodule

FILE: verif/association_confirm_tracker_unit_test.sv
`timescale 1ns / 1ps

module association_confirm_tracker_unit_test;

	localparam int ENTRIES      = 32;
	localparam int ITEMS        = 540;
	localparam int CALM_ITEMS   = 60;
	localparam int DRAIN_CYCLES = ENTRIES + ENTRIES * ENTRIES + 12;
	localparam int CYCLE_LIMIT  = 4_000_000;

	// the package stops at confirm; the spare code must be ignored by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam bit TYPED   = 1'b1;
	localparam bit PREDICT = 1'b0;

	typedef struct packed {
		act_pkg::act_req_t req;
		logic              typed;
		act_pkg::act_rsp_t want;
	} script_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	act_pkg::act_req_t req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	act_pkg::act_rsp_t rsp;

	// predictor copy of both tables
	logic [7:0] base_tag [ENTRIES];
	logic [7:0] base_fmt [ENTRIES];
	int         base_len = 0;
	logic [7:0] seen_tag [ENTRIES];
	logic [7:0] seen_fmt [ENTRIES];
	int         seen_len = 0;

	act_pkg::act_rsp_t outcome_q [$];
	bit       failed     = 1'b0;
	bit       quiet      = 1'b0;
	int       sent       = 0;
	int       sessions   = 0;
	int       big_left   = 4;
	int       stall_left = 0;
	int       cycles     = 0;

	// directed transactions; flag order in the typed results is accepted, added, done, reset
	localparam int SCRIPT_LEN = 23;
	script_row_t script [SCRIPT_LEN] = '{
		// confirm against an empty reference table is done at once
		{act_pkg::CMD_CONFIRM, 8'h00, 8'h00, 8'h00, TYPED,   4'b0010, 6'd0, 6'd0},
		// spare command code leaves everything alone
		{CMD_UNUSED,           8'hff, 8'hff, 8'hff, TYPED,   4'b0000, 6'd0, 6'd0},
		{act_pkg::CMD_APPEND,  8'h00, 8'h00, 8'h00, TYPED,   4'b0100, 6'd0, 6'd1},
		{act_pkg::CMD_APPEND,  8'hff, 8'hff, 8'hff, TYPED,   4'b0100, 6'd0, 6'd2},
		{act_pkg::CMD_CONFIRM, 8'hff, 8'h02, 8'hff, PREDICT, 16'h0000},
		// wrong count, then a pair that is not in the table
		{act_pkg::CMD_CONFIRM, 8'h00, 8'h01, 8'h00, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'h00, 8'h02, 8'hff, PREDICT, 16'h0000},
		// repeat of an already confirmed pair
		{act_pkg::CMD_CONFIRM, 8'hff, 8'h02, 8'hff, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'hff, 8'hff, 8'hff, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'h00, 8'h02, 8'h00, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'h00, 8'h02, 8'h00, PREDICT, 16'h0000},
		{act_pkg::CMD_CLEAR,   8'hff, 8'hff, 8'hff, TYPED,   4'b0000, 6'd0, 6'd0},
		{act_pkg::CMD_CLEAR,   8'h00, 8'h00, 8'h00, TYPED,   4'b0000, 6'd0, 6'd0},
		// duplicate reference pairs
		{act_pkg::CMD_APPEND,  8'h5a, 8'h00, 8'ha5, TYPED,   4'b0100, 6'd0, 6'd1},
		{act_pkg::CMD_APPEND,  8'h5a, 8'h00, 8'ha5, TYPED,   4'b0100, 6'd0, 6'd2},
		{act_pkg::CMD_APPEND,  8'h3c, 8'h00, 8'hc3, TYPED,   4'b0100, 6'd0, 6'd3},
		{act_pkg::CMD_CONFIRM, 8'h5a, 8'h03, 8'ha5, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'h3c, 8'h03, 8'hc3, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'ha5, 8'h03, 8'h5a, PREDICT, 16'h0000},
		{act_pkg::CMD_APPEND,  8'ha5, 8'h00, 8'h5a, PREDICT, 16'h0000},
		{act_pkg::CMD_CONFIRM, 8'ha5, 8'h04, 8'h5a, PREDICT, 16'h0000},
		{CMD_UNUSED,           8'h00, 8'h00, 8'h00, PREDICT, 16'h0000},
		{act_pkg::CMD_CLEAR,   8'h00, 8'h00, 8'h00, TYPED,   4'b0000, 6'd0, 6'd0}
	};

	association_confirm_tracker_unit #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// expected result of one transaction, updating the predictor tables
	function automatic act_pkg::act_rsp_t predict_outcome(act_pkg::act_req_t r);
		act_pkg::act_rsp_t o;
		bit       in_base;
		bit       in_seen;
		int       hits;
		o = '0;
		case (r.command)
			act_pkg::CMD_CLEAR: begin
				base_len = 0;
				seen_len = 0;
			end
			act_pkg::CMD_APPEND: begin
				if (base_len < ENTRIES) begin
					base_tag[base_len] = r.tag;
					base_fmt[base_len] = r.format;
					base_len++;
					o.added = 1'b1;
				end
			end
			act_pkg::CMD_CONFIRM: begin
				in_base = 1'b0;
				for (int k = 0; k < base_len; k++)
					if (base_tag[k] == r.tag && base_fmt[k] == r.format)
						in_base = 1'b1;
				if (int'(r.count) == base_len && in_base) begin
					o.accepted = 1'b1;
					in_seen = 1'b0;
					for (int k = 0; k < seen_len; k++)
						if (seen_tag[k] == r.tag && seen_fmt[k] == r.format)
							in_seen = 1'b1;
					if (!in_seen && seen_len < ENTRIES) begin
						seen_tag[seen_len] = r.tag;
						seen_fmt[seen_len] = r.format;
						seen_len++;
						o.added = 1'b1;
					end
				end
				// every matching pair of entries counts, only with equal counts
				hits = 0;
				if (base_len == seen_len)
					for (int u = 0; u < seen_len; u++)
						for (int k = 0; k < base_len; k++)
							if (base_tag[k] == seen_tag[u] && base_fmt[k] == seen_fmt[u])
								hits++;
				if (hits == base_len) begin
					o.done_res = 1'b1;
				end else if (seen_len >= base_len) begin
					seen_len = 0;
					o.reset_confirmed = 1'b1;
				end
			end
			default: ;
		endcase
		o.confirmed_count = act_pkg::RSP_COUNT_W'(seen_len);
		o.reference_count = act_pkg::RSP_COUNT_W'(base_len);
		return o;
	endfunction

	// present one transaction, with an occasional idle burst ahead of it
	task automatic drive(act_pkg::act_req_t item, bit typed, act_pkg::act_rsp_t want);
		act_pkg::act_rsp_t guess;
		int       gap;
		@(negedge clk);
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		guess = predict_outcome(item);
		outcome_q.push_back(typed ? want : guess);
		if (item.command != CMD_UNUSED)
			sent++;
		if (sent >= ITEMS + SCRIPT_LEN - CALM_ITEMS)
			quiet = 1'b1;
	endtask

	// one random session: mostly fill and confirm, sometimes plain noise
	task automatic run_session();
		act_pkg::act_req_t item;
		int       n;
		int       n_ref;
		int       steps;
		int       next;
		int       pick;
		int       tmp;
		int       roll;
		int       i;
		int       order [ENTRIES];
		item = '0;
		sessions++;
		// noise: any command code and any field values
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				item.command = 2'($urandom_range(0, 3));
				item.tag     = 8'($urandom_range(0, 255));
				item.count   = 8'($urandom_range(0, 255));
				item.format  = 8'($urandom_range(0, 255));
				drive(item, PREDICT, '0);
			end
			return;
		end
		// usually start from empty tables
		if ($urandom_range(0, 4) != 0) begin
			item.command = act_pkg::CMD_CLEAR;
			item.tag     = 8'($urandom_range(0, 255));
			item.count   = 8'($urandom_range(0, 255));
			item.format  = 8'($urandom_range(0, 255));
			drive(item, PREDICT, '0);
		end
		// table size: mostly small, a few runs fill past the top
		if (big_left > 0 && (sessions == 3 || $urandom_range(0, 29) == 0)) begin
			n = $urandom_range(ENTRIES, ENTRIES + 3);
			big_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(7, 12);
		end else begin
			n = $urandom_range(1, 6);
		end
		for (i = 0; i < n; i++) begin
			item.command = act_pkg::CMD_APPEND;
			item.count   = 8'($urandom_range(0, 255));
			if (i > 0 && $urandom_range(0, 7) == 0) begin
				tmp         = $urandom_range(0, base_len - 1);
				item.tag    = base_tag[tmp];
				item.format = base_fmt[tmp];
			end else if ($urandom_range(0, 1) == 0) begin
				item.tag    = 8'($urandom_range(0, 3));
				item.format = 8'($urandom_range(0, 3));
			end else begin
				item.tag    = 8'($urandom_range(0, 255));
				item.format = 8'($urandom_range(0, 255));
			end
			drive(item, PREDICT, '0);
		end
		// confirm the stored pairs in shuffled order, mixed with repeats and bad triples
		n_ref = base_len;
		for (i = 0; i < n_ref; i++)
			order[i] = i;
		for (i = n_ref - 1; i > 0; i--) begin
			pick     = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[pick];
			order[pick] = tmp;
		end
		steps = n_ref + $urandom_range(0, 3);
		next  = 0;
		repeat (steps) begin
			if ($urandom_range(0, 29) == 0) begin
				item.command = act_pkg::CMD_APPEND;
				item.tag     = 8'($urandom_range(0, 255));
				item.format  = 8'($urandom_range(0, 255));
				drive(item, PREDICT, '0);
			end
			roll         = $urandom_range(0, 9);
			item.command = act_pkg::CMD_CONFIRM;
			item.count   = 8'(base_len);
			if (roll == 9) begin
				item.tag    = 8'($urandom_range(0, 255));
				item.format = 8'($urandom_range(0, 255));
			end else begin
				if (roll < 7 && next < n_ref) begin
					pick = order[next];
					next++;
				end else begin
					pick = $urandom_range(0, n_ref - 1);
				end
				item.tag    = base_tag[pick];
				item.format = base_fmt[pick];
				if (roll == 8)
					item.count = 8'($urandom_range(0, 255));
			end
			drive(item, PREDICT, '0);
		end
	endtask

	// result side stalls in short random bursts
	always @(negedge clk) begin
		if (quiet) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		act_pkg::act_rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (outcome_q.size() == 0) begin
				$error("result transaction with nothing expected: %h", rsp);
				failed = 1'b1;
			end else begin
				want = outcome_q.pop_front();
				if (rsp.accepted !== want.accepted) begin
					$error("accepted: expected %0d, actual %0d", want.accepted, rsp.accepted);
					failed = 1'b1;
				end
				if (rsp.added !== want.added) begin
					$error("added: expected %0d, actual %0d", want.added, rsp.added);
					failed = 1'b1;
				end
				if (rsp.done_res !== want.done_res) begin
					$error("done_res: expected %0d, actual %0d", want.done_res, rsp.done_res);
					failed = 1'b1;
				end
				if (rsp.reset_confirmed !== want.reset_confirmed) begin
					$error("reset_confirmed: expected %0d, actual %0d",
						want.reset_confirmed, rsp.reset_confirmed);
					failed = 1'b1;
				end
				if (rsp.confirmed_count !== want.confirmed_count) begin
					$error("confirmed_count: expected %0d, actual %0d",
						want.confirmed_count, rsp.confirmed_count);
					failed = 1'b1;
				end
				if (rsp.reference_count !== want.reference_count) begin
					$error("reference_count: expected %0d, actual %0d",
						want.reference_count, rsp.reference_count);
					failed = 1'b1;
				end
			end
		end
	end

	// guard against a hang
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// reset, directed table, random sessions, then drain
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int r = 0; r < SCRIPT_LEN; r++)
			drive(script[r].req, script[r].typed, script[r].want);
		while (sent < ITEMS + SCRIPT_LEN)
			run_session();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
